@@ hdl/srsf_pkg.sv @@
// ----------------------------------------------------------------------------
// srsf_pkg: shared types and constants for the stream register snoop filter
// Transaction codes, result record and fixed field widths.
// ----------------------------------------------------------------------------
package srsf_pkg;

  // transaction kinds; the fourth code is unused and does nothing
  typedef enum logic [1:0] {
    ACT_MISS  = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_INVAL = 2'd2
  } action_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // one result record, as it leaves the block
  typedef struct packed {
    logic       filter_hit;
    logic [1:0] chosen_slot;
    logic       slot_allocated;
    logic [2:0] released_count;
  } result_t;

endpackage

@@ hdl/srsf_ram.sv @@
// ----------------------------------------------------------------------------
// srsf_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module srsf_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 4,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/srsf_row_update.sv @@
// ----------------------------------------------------------------------------
// srsf_row_update: modify step for one CPU's row of stream registers
// Matches the address against every register of the row, then trains,
// queries or counts down as the transaction asks.
// ----------------------------------------------------------------------------
module srsf_row_update #(
  parameter  int REGS_PER_CPU = 4,
  parameter  int ADDR_BITS    = 16,
  localparam int ENTRY_W      = 2 * ADDR_BITS + srsf_pkg::COUNT_W,
  localparam int ROW_W        = REGS_PER_CPU * ENTRY_W
) (
  input  srsf_pkg::action_e        action_i,
  input  logic                     cpu_ok_i,
  input  logic [ADDR_BITS-1:0]     addr_i,
  input  logic [ROW_W-1:0]         row_i,
  input  logic [REGS_PER_CPU-1:0]  valid_i,
  output logic [ROW_W-1:0]         row_o,
  output logic [REGS_PER_CPU-1:0]  valid_o,
  output logic                     we_o,
  output srsf_pkg::result_t        res_o
);
  import srsf_pkg::*;

  localparam int RW  = (REGS_PER_CPU > 1) ? $clog2(REGS_PER_CPU) : 1;
  localparam int DW  = $clog2(ADDR_BITS + 1);
  localparam int RCW = $clog2(REGS_PER_CPU + 1);

  logic [ADDR_BITS-1:0] base     [REGS_PER_CPU];
  logic [ADDR_BITS-1:0] mask     [REGS_PER_CPU];
  logic [COUNT_W-1:0]   cnt      [REGS_PER_CPU];
  logic [ADDR_BITS-1:0] diff     [REGS_PER_CPU];
  logic [DW-1:0]        ham_dist [REGS_PER_CPU];
  logic [REGS_PER_CPU-1:0] match;

  // per-register compare, all lanes side by side
  always_comb begin
    for (int i = 0; i < REGS_PER_CPU; i++) begin
      base[i]     = row_i[i*ENTRY_W +: ADDR_BITS];
      mask[i]     = row_i[i*ENTRY_W + ADDR_BITS +: ADDR_BITS];
      cnt[i]      = row_i[i*ENTRY_W + 2*ADDR_BITS +: COUNT_W];
      diff[i]     = base[i] ^ addr_i;
      match[i]    = ((diff[i] & mask[i]) == '0);
      ham_dist[i] = DW'($countones(diff[i]));
    end
  end

  // miss: first free or matching register, else nearest base (later wins ties)
  logic          found;
  logic [RW-1:0] first_idx;
  logic [RW-1:0] near_idx;
  logic [DW-1:0] best;
  logic [RW-1:0] pick;

  always_comb begin
    found     = 1'b0;
    first_idx = '0;
    near_idx  = '0;
    best      = '0;
    for (int i = 0; i < REGS_PER_CPU; i++) begin
      if (!found && (!valid_i[i] || match[i])) begin
        found     = 1'b1;
        first_idx = RW'(i);
      end
      if (i == 0 || ham_dist[i] <= best) begin
        best     = ham_dist[i];
        near_idx = RW'(i);
      end
    end
    pick = found ? first_idx : near_idx;
  end

  logic [RCW-1:0] released;

  always_comb begin
    row_o    = row_i;
    valid_o  = valid_i;
    we_o     = 1'b0;
    res_o    = '0;
    released = '0;
    if (cpu_ok_i) begin
      unique case (action_i)
        ACT_MISS: begin
          we_o               = 1'b1;
          res_o.chosen_slot  = 2'(pick);
          valid_o[pick]      = 1'b1;
          row_o[32'(pick)*ENTRY_W +: ADDR_BITS] = addr_i;
          if (!valid_i[pick]) begin
            // fresh register: all-ones mask, count two
            res_o.slot_allocated = 1'b1;
            row_o[32'(pick)*ENTRY_W + ADDR_BITS +: ADDR_BITS] = '1;
            row_o[32'(pick)*ENTRY_W + 2*ADDR_BITS +: COUNT_W] = COUNT_W'(2);
          end else begin
            row_o[32'(pick)*ENTRY_W + ADDR_BITS +: ADDR_BITS] =
                mask[pick] & ~diff[pick];
            row_o[32'(pick)*ENTRY_W + 2*ADDR_BITS +: COUNT_W] =
                (cnt[pick] == COUNT_MAX) ? cnt[pick] : cnt[pick] + COUNT_W'(1);
          end
        end
        ACT_QUERY: begin
          res_o.filter_hit = |(valid_i & match);
        end
        ACT_INVAL: begin
          we_o = 1'b1;
          for (int i = 0; i < REGS_PER_CPU; i++) begin
            if (valid_i[i] && match[i]) begin
              if (cnt[i] <= COUNT_W'(1)) begin
                row_o[i*ENTRY_W + 2*ADDR_BITS +: COUNT_W] = '0;
                valid_o[i] = 1'b0;
                released   = released + RCW'(1);
              end else begin
                row_o[i*ENTRY_W + 2*ADDR_BITS +: COUNT_W] = cnt[i] - COUNT_W'(1);
              end
            end
          end
          res_o.released_count = 3'(released);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/stream_register_snoop_filter_core.sv @@
// ----------------------------------------------------------------------------
// stream_register_snoop_filter_core: per-CPU stream register snoop filter
// Trains stream registers on local misses, answers snoop queries and counts
// registers down on snoop invalidates.
// ----------------------------------------------------------------------------
// A transaction is taken when start_i is high and busy_o is low. The accept
// cycle reads the CPU's row of stream registers from the row RAM, the next
// cycle (busy_o high) compares, modifies and writes the row back while the
// result is registered. result_valid_o then pulses for exactly one cycle, in
// the cycle after busy_o, and the receiver must take it there: there is no
// back-pressure. A new transaction may be started in that same cycle, but
// none is taken while busy_o is high, held off by the RAM's read-then-write
// turn on the row. Valid bits live in flip-flops and are cleared by reset,
// so no clearing pass is needed and the block is ready right after reset.
// Result fields that do not belong to the action are zero; an unused action
// code or a CPU number at or above CPU_COUNT changes nothing and returns an
// all-zero result.
// ----------------------------------------------------------------------------
module stream_register_snoop_filter_core #(
  parameter int REGS_PER_CPU = 4,
  parameter int CPU_COUNT    = 4,
  parameter int ADDR_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [1:0]  cpu_i,
  input  logic [15:0] address_i,
  output logic        result_valid_o,
  output logic        filter_hit_o,
  output logic [1:0]  chosen_slot_o,
  output logic        slot_allocated_o,
  output logic [2:0]  released_count_o
);
  import srsf_pkg::*;

  localparam int CPU_AW  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int ENTRY_W = 2 * ADDR_BITS + COUNT_W;
  localparam int ROW_W   = REGS_PER_CPU * ENTRY_W;

  state_e state_q, state_d;
  logic   accept;

  // transaction latched at accept
  action_e              action_q;
  logic [CPU_AW-1:0]    cpu_q;
  logic                 cpu_ok_q;
  logic [ADDR_BITS-1:0] addr_q;

  logic [CPU_COUNT-1:0][REGS_PER_CPU-1:0] valid_q;

  logic [ROW_W-1:0]        row_rd;
  logic [ROW_W-1:0]        row_wr;
  logic [REGS_PER_CPU-1:0] valid_row;
  logic [REGS_PER_CPU-1:0] valid_new;
  logic                    upd_we;
  logic                    row_we;
  result_t                 res_d;
  result_t                 res_q;
  logic                    res_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs of the control
  always_comb begin
    busy_o = 1'b0;
    unique case (state_q)
      ST_IDLE: busy_o = 1'b0;
      ST_EXEC: busy_o = 1'b1;
      default: busy_o = 1'b0;
    endcase
  end

  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == ST_EXEC);
    end
  end

  // payload of the transaction and the result record
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_e'(action_i);
      cpu_q    <= CPU_AW'(cpu_i);
      cpu_ok_q <= (32'(cpu_i) < CPU_COUNT);
      addr_q   <= ADDR_BITS'(address_i);
    end
    if (state_q == ST_EXEC) begin
      res_q <= res_d;
    end
  end

  // one row per CPU; busy_o keeps the next read behind this write-back
  srsf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CPU_COUNT)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (cpu_q),
    .wdata_i (row_wr),
    .re_i    (accept),
    .raddr_i (CPU_AW'(cpu_i)),
    .rdata_o (row_rd)
  );

  assign valid_row = cpu_ok_q ? valid_q[cpu_q] : '0;

  srsf_row_update #(
    .REGS_PER_CPU (REGS_PER_CPU),
    .ADDR_BITS    (ADDR_BITS)
  ) u_row_update (
    .action_i (action_q),
    .cpu_ok_i (cpu_ok_q),
    .addr_i   (addr_q),
    .row_i    (row_rd),
    .valid_i  (valid_row),
    .row_o    (row_wr),
    .valid_o  (valid_new),
    .we_o     (upd_we),
    .res_o    (res_d)
  );

  assign row_we = upd_we && (state_q == ST_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (row_we) begin
      valid_q[cpu_q] <= valid_new;
    end
  end

  assign result_valid_o   = res_valid_q;
  assign filter_hit_o     = res_q.filter_hit;
  assign chosen_slot_o    = res_q.chosen_slot;
  assign slot_allocated_o = res_q.slot_allocated;
  assign released_count_o = res_q.released_count;

`ifndef ASSERT_OFF
  // an accepted transaction raises busy_o for its work cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accept not followed by work cycle");

  a_busy_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> (!busy_o && result_valid_o))
    else $error("work cycle did not end in a result");

  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result without a preceding work cycle");

  a_no_stray_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_we |-> (cpu_ok_q && (action_q == ACT_MISS || action_q == ACT_INVAL)))
    else $error("row written for a transaction that changes nothing");

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(filter_hit_o && (released_count_o != 3'd0)))
    else $error("query and invalidate fields both set");
`endif

endmodule
